// ===== hw/rtl/tsnb_pkg.sv =====
// tsnb_pkg: operation codes, register indexes and fixed constants of the
// texture sampler (nearest and 2x2 box). No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsnb_pkg;

	localparam int OP_W = 2;
	localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
	localparam logic [OP_W-1:0] OP_NEAREST = 2'd1;
	localparam logic [OP_W-1:0] OP_BOX     = 2'd2;

	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_TEX_WIDTH     = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_TEX_HEIGHT    = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

	// signed Q2.16 coordinate, clamped to 0..1.0
	localparam int COORD_W = 18;
	localparam int UNIT_W  = 17;
	localparam logic [UNIT_W-1:0] ONE_Q16 = 17'h10000;
	localparam int FRAC_BITS = 16;

	localparam int CHAN_CNT_W  = 3;
	localparam int PORT_CHANS  = 4;
	localparam int DIM_RESET   = 128;
	localparam int CHAN_RESET  = 4;

endpackage

`default_nettype wire

// ===== hw/rtl/tsnb_texel_bank.sv =====
// tsnb_texel_bank: one parity bank of the texel store, single port,
// registered read data held while not enabled. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tsnb_texel_bank #(
	parameter int AW = 12,
	parameter int DW = 32
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic          we,
	input  wire logic [AW-1:0] addr,
	input  wire logic [DW-1:0] wdata,
	output logic      [DW-1:0] rdata
);

	localparam int DEPTH = 1 << AW;

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/texture_sampler_nearest_box_unit.sv =====
// texture_sampler_nearest_box_unit: texel store with nearest and 2x2 box sampling.
// Depends on tsnb_pkg and tsnb_texel_bank (four banks split by column/row parity).
//
// Channel   Handshake                Payload
// --------  -----------------------  ------------------------------------------
// in        in_valid / in_stall      operation, x_pos, y_pos, chan_in_0..3,
//                                    u_coord, v_coord
// out       out_valid / out_stall    chan_out_0..3 (one per sample, none per write)
// cfg       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One transaction per cycle sustained while in_stall is low; an accepted sample passes
// the input reg, index reg, bank read and output reg on its way to out.
// The four parity banks serve all texels of a 2x2 footprint in a single read.
// Output register plus one skid entry: in_stall rises only when both hold results.
// Reset clears valids and sets config registers to their reset values; the texel store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module texture_sampler_nearest_box_unit
	import tsnb_pkg::*;
#(
	parameter int MAX_WIDTH    = 128,
	parameter int MAX_HEIGHT   = 128,
	parameter int MAX_CHANNELS = 4,
	parameter int CHANNEL_BITS = 8,
	localparam int XW     = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1,
	localparam int YW     = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1,
	localparam int DIM_MAX = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT,
	localparam int CFG_W  = ($clog2(DIM_MAX + 1) > 8) ? $clog2(DIM_MAX + 1) : 8
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,

	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [OP_W-1:0]          operation,
	input  wire logic [XW-1:0]            x_pos,
	input  wire logic [YW-1:0]            y_pos,
	input  wire logic [CHANNEL_BITS-1:0]  chan_in_0,
	input  wire logic [CHANNEL_BITS-1:0]  chan_in_1,
	input  wire logic [CHANNEL_BITS-1:0]  chan_in_2,
	input  wire logic [CHANNEL_BITS-1:0]  chan_in_3,
	input  wire logic signed [COORD_W-1:0] u_coord,
	input  wire logic signed [COORD_W-1:0] v_coord,

	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [CHANNEL_BITS-1:0]       chan_out_0,
	output logic [CHANNEL_BITS-1:0]       chan_out_1,
	output logic [CHANNEL_BITS-1:0]       chan_out_2,
	output logic [CHANNEL_BITS-1:0]       chan_out_3,

	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [REG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_W-1:0]         cfg_data
);

	localparam int WDW = $clog2(MAX_WIDTH + 1);
	localparam int HDW = $clog2(MAX_HEIGHT + 1);
	localparam int XHW = (XW > 1) ? XW - 1 : 1;
	localparam int YHW = (YW > 1) ? YW - 1 : 1;
	localparam int BAW = XHW + YHW;
	localparam int NCH = MAX_CHANNELS;
	localparam int CB  = CHANNEL_BITS;
	localparam int TW  = NCH * CB;
	localparam int PWU = UNIT_W + WDW;
	localparam int PWV = UNIT_W + HDW;
	localparam int W_RST = (DIM_RESET > MAX_WIDTH)  ? MAX_WIDTH  : DIM_RESET;
	localparam int H_RST = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET;
	localparam int C_RST = (CHAN_RESET > MAX_CHANNELS) ? MAX_CHANNELS : CHAN_RESET;

	// configuration, stored already saturated
	logic [WDW-1:0]        tex_w_q;
	logic [HDW-1:0]        tex_h_q;
	logic [CHAN_CNT_W-1:0] nc_q;
	logic [WDW-1:0]        w_sat;
	logic [HDW-1:0]        h_sat;
	logic [CHAN_CNT_W-1:0] nc_sat;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (cfg_data < CFG_W'(2)) begin
			w_sat = WDW'(2);
		end else if (cfg_data > CFG_W'(MAX_WIDTH)) begin
			w_sat = WDW'(MAX_WIDTH);
		end else begin
			w_sat = WDW'(cfg_data);
		end
		if (cfg_data < CFG_W'(2)) begin
			h_sat = HDW'(2);
		end else if (cfg_data > CFG_W'(MAX_HEIGHT)) begin
			h_sat = HDW'(MAX_HEIGHT);
		end else begin
			h_sat = HDW'(cfg_data);
		end
		if (cfg_data[CHAN_CNT_W-1:0] < CHAN_CNT_W'(1)) begin
			nc_sat = CHAN_CNT_W'(1);
		end else if (cfg_data[CHAN_CNT_W-1:0] > CHAN_CNT_W'(MAX_CHANNELS)) begin
			nc_sat = CHAN_CNT_W'(MAX_CHANNELS);
		end else begin
			nc_sat = cfg_data[CHAN_CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_w_q <= WDW'(W_RST);
			tex_h_q <= HDW'(H_RST);
			nc_q    <= CHAN_CNT_W'(C_RST);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TEX_WIDTH:     tex_w_q <= w_sat;
				REG_TEX_HEIGHT:    tex_h_q <= h_sat;
				REG_CHANNEL_COUNT: nc_q    <= nc_sat;
				default: ;
			endcase
		end
	end

	// pipeline advance: frozen only while the skid entry is occupied
	logic skid_valid_q;
	logic adv;
	logic in_acc;

	assign adv      = !skid_valid_q;
	assign in_stall = skid_valid_q;
	assign in_acc   = in_valid && adv;

	// stage 1: input register
	logic [CB-1:0] din [PORT_CHANS];
	assign din[0] = chan_in_0;
	assign din[1] = chan_in_1;
	assign din[2] = chan_in_2;
	assign din[3] = chan_in_3;

	logic                      v_s1;
	logic [OP_W-1:0]           op_s1;
	logic [XW-1:0]             xw_s1;
	logic [YW-1:0]             yw_s1;
	logic [TW-1:0]             wd_s1;
	logic signed [COORD_W-1:0] u_s1;
	logic signed [COORD_W-1:0] vcrd_s1;
	logic [TW-1:0]             wd_in;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			wd_in[c*CB +: CB] = (CHAN_CNT_W'(c) < nc_q) ? din[c] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1   <= operation;
			xw_s1   <= x_pos;
			yw_s1   <= y_pos;
			wd_s1   <= wd_in;
			u_s1    <= u_coord;
			vcrd_s1 <= v_coord;
		end
	end

	// stage 1 logic: clamp to 0..1.0, scale by size
	logic [UNIT_W-1:0] uc, vc;
	logic [PWU-1:0]    pu;
	logic [PWV-1:0]    pv;
	logic              wr_ok_s1;

	always_comb begin
		if (u_s1[COORD_W-1]) begin
			uc = '0;
		end else if (u_s1[UNIT_W-1:0] > ONE_Q16) begin
			uc = ONE_Q16;
		end else begin
			uc = u_s1[UNIT_W-1:0];
		end
		if (vcrd_s1[COORD_W-1]) begin
			vc = '0;
		end else if (vcrd_s1[UNIT_W-1:0] > ONE_Q16) begin
			vc = ONE_Q16;
		end else begin
			vc = vcrd_s1[UNIT_W-1:0];
		end
		pu = PWU'(uc) * PWU'(tex_w_q);
		pv = PWV'(vc) * PWV'(tex_h_q);
		wr_ok_s1 = (WDW'(xw_s1) < tex_w_q) && (HDW'(yw_s1) < tex_h_q);
	end

	// stage 2
	logic            v_s2;
	logic [OP_W-1:0] op_s2;
	logic [XW-1:0]   xw_s2;
	logic [YW-1:0]   yw_s2;
	logic [TW-1:0]   wd_s2;
	logic            wr_ok_s2;
	logic [WDW-1:0]  ix_s2;
	logic [HDW-1:0]  iy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2    <= op_s1;
			xw_s2    <= xw_s1;
			yw_s2    <= yw_s1;
			wd_s2    <= wd_s1;
			wr_ok_s2 <= wr_ok_s1;
			ix_s2    <= pu[FRAC_BITS +: WDW];
			iy_s2    <= pv[FRAC_BITS +: HDW];
		end
	end

	// stage 2 logic: clamp indexes, pick the footprint texel per bank
	logic           is_box, is_smp, is_wr;
	logic [WDW-1:0] x_hi, x_lo, xi;
	logic [HDW-1:0] y_hi, y_lo, yi;
	logic [XW-1:0]  xq, xm;
	logic [YW-1:0]  yq, ym;
	logic [XHW-1:0] xwh;
	logic [YHW-1:0] ywh;

	always_comb begin
		is_box = (op_s2 == OP_BOX);
		is_smp = (op_s2 == OP_NEAREST) || (op_s2 == OP_BOX);
		is_wr  = (op_s2 == OP_WRITE) && wr_ok_s2;
		x_hi = tex_w_q - WDW'(1);
		y_hi = tex_h_q - HDW'(1);
		x_lo = is_box ? WDW'(1) : '0;
		y_lo = is_box ? HDW'(1) : '0;
		if (ix_s2 > x_hi) begin
			xi = x_hi;
		end else if (ix_s2 < x_lo) begin
			xi = x_lo;
		end else begin
			xi = ix_s2;
		end
		if (iy_s2 > y_hi) begin
			yi = y_hi;
		end else if (iy_s2 < y_lo) begin
			yi = y_lo;
		end else begin
			yi = iy_s2;
		end
		xq  = XW'(xi);
		yq  = YW'(yi);
		xm  = is_box ? xq - XW'(1) : xq;
		ym  = is_box ? yq - YW'(1) : yq;
		xwh = XHW'(xw_s2 >> 1);
		ywh = YHW'(yw_s2 >> 1);
	end

	// stage 3: bank read data plus sample control
	logic          v_s3;
	logic          box_s3;
	logic [1:0]    par_s3;
	logic [TW-1:0] rd [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2 && is_smp;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			box_s3 <= is_box;
			par_s3 <= {yq[0], xq[0]};
		end
	end

	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic BX = 1'(b);
		localparam logic BY = 1'(b >> 1);
		logic [XW-1:0]  col;
		logic [YW-1:0]  row;
		logic [BAW-1:0] addr;
		logic           wsel;
		logic           en;

		always_comb begin
			col  = (xq[0] == BX) ? xq : xm;
			row  = (yq[0] == BY) ? yq : ym;
			wsel = is_wr && (xw_s2[0] == BX) && (yw_s2[0] == BY);
			en   = adv && v_s2 && (is_smp || wsel);
			if (wsel) begin
				addr = {ywh, xwh};
			end else begin
				addr = {YHW'(row >> 1), XHW'(col >> 1)};
			end
		end

		tsnb_texel_bank #(
			.AW (BAW),
			.DW (TW)
		) u_bank (
			.clk   (clk),
			.en    (en),
			.we    (wsel),
			.addr  (addr),
			.wdata (wd_s2),
			.rdata (rd[b])
		);
	end

	// stage 3 logic: nearest select or truncated 2x2 mean
	logic [CB-1:0] res [PORT_CHANS];

	for (genvar c = 0; c < PORT_CHANS; c++) begin : g_lane
		if (c < NCH) begin : g_used
			logic [CB+1:0] sum;
			logic [CB-1:0] val;
			always_comb begin
				sum = (CB+2)'(rd[0][c*CB +: CB]) + (CB+2)'(rd[1][c*CB +: CB])
				    + (CB+2)'(rd[2][c*CB +: CB]) + (CB+2)'(rd[3][c*CB +: CB]);
				val = box_s3 ? sum[CB+1:2] : rd[par_s3][c*CB +: CB];
				res[c] = (CHAN_CNT_W'(c) < nc_q) ? val : '0;
			end
		end else begin : g_unused
			assign res[c] = '0;
		end
	end

	// output register and skid entry
	logic          out_valid_q;
	logic [CB-1:0] out_q  [PORT_CHANS];
	logic [CB-1:0] skid_q [PORT_CHANS];
	logic          take, produce;

	assign take    = out_valid_q && !out_stall;
	assign produce = adv && v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (produce) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (produce) begin
			if (out_valid_q && !take) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign chan_out_0 = out_q[0];
	assign chan_out_1 = out_q[1];
	assign chan_out_2 = out_q[2];
	assign chan_out_3 = out_q[3];

	// checks
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without a pending output");

	a_skid_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid entry filled while output was free");

	a_pipe_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |=> ($stable(v_s3) && $stable(v_s2) && $stable(v_s1)))
		else $error("pipeline moved while skid entry was full");

	a_cfg_range: assert property (@(posedge clk) disable iff (!arst_n)
		(tex_w_q >= WDW'(2)) && (tex_w_q <= WDW'(MAX_WIDTH))
		&& (tex_h_q >= HDW'(2)) && (tex_h_q <= HDW'(MAX_HEIGHT))
		&& (nc_q >= CHAN_CNT_W'(1)) && (nc_q <= CHAN_CNT_W'(MAX_CHANNELS)))
		else $error("configuration register outside its saturated range");

endmodule

`default_nettype wire

// ===== verif/texture_sampler_nearest_box_checker.sv =====
// Checker for texture_sampler_nearest_box_unit: watches the in, out and cfg channels,
// keeps its own texel store and register copy, predicts each sample and compares.
// Depends on tsnb_pkg for codes, register indexes and coordinate constants.
`timescale 1ns / 1ps

module texture_sampler_nearest_box_checker
	import tsnb_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic                      in_stall,
	input  wire logic [OP_W-1:0]           operation,
	input  wire logic [6:0]                x_pos,
	input  wire logic [6:0]                y_pos,
	input  wire logic [7:0]                chan_in_0,
	input  wire logic [7:0]                chan_in_1,
	input  wire logic [7:0]                chan_in_2,
	input  wire logic [7:0]                chan_in_3,
	input  wire logic signed [COORD_W-1:0] u_coord,
	input  wire logic signed [COORD_W-1:0] v_coord,
	input  wire logic                      out_valid,
	input  wire logic                      out_stall,
	input  wire logic [7:0]                chan_out_0,
	input  wire logic [7:0]                chan_out_1,
	input  wire logic [7:0]                chan_out_2,
	input  wire logic [7:0]                chan_out_3,
	input  wire logic                      cfg_valid,
	input  wire logic                      cfg_ready,
	input  wire logic [REG_IDX_W-1:0]      cfg_index,
	input  wire logic [7:0]                cfg_data,
	output int                             fail_count,
	output int                             open_count,
	output int                             checked_count
);

	localparam int DIM = 128;

	typedef logic [PORT_CHANS-1:0][7:0] texel_t;

	texel_t texel_mem [0:DIM*DIM-1];
	texel_t expected_texels [$];
	logic [7:0] width_reg;
	logic [7:0] height_reg;
	logic [CHAN_CNT_W-1:0] chans_reg;
	int mismatches;
	int compared;

	initial begin
		for (int i = 0; i < DIM * DIM; i++) begin
			texel_mem[i] = '0;
		end
		mismatches = 0;
		compared = 0;
	end

	function automatic int unsigned clamp_to(int unsigned val, int unsigned lo,
			int unsigned hi);
		if (val < lo) begin
			return lo;
		end
		if (val > hi) begin
			return hi;
		end
		return val;
	endfunction

	// coordinate clamped to 0..1.0, scaled by size, floor taken, then clamped to lo..size-1
	function automatic int unsigned texel_index_of(logic signed [COORD_W-1:0] coord,
			int unsigned size, int unsigned lo);
		int s;
		int unsigned idx;
		s = coord;
		if (s < 0) begin
			s = 0;
		end else if (s > int'(ONE_Q16)) begin
			s = int'(ONE_Q16);
		end
		idx = (s * size) >> FRAC_BITS;
		return clamp_to(idx, lo, size - 1);
	endfunction

	function automatic texel_t filter_texels(logic [OP_W-1:0] op,
			logic signed [COORD_W-1:0] u, logic signed [COORD_W-1:0] v);
		int unsigned w, h, nc, lo, x, y, sum;
		int c;
		texel_t res;
		w = clamp_to(width_reg, 2, DIM);
		h = clamp_to(height_reg, 2, DIM);
		nc = clamp_to(chans_reg, 1, PORT_CHANS);
		lo = (op == OP_BOX) ? 1 : 0;
		x = texel_index_of(u, w, lo);
		y = texel_index_of(v, h, lo);
		res = '0;
		for (c = 0; c < PORT_CHANS; c++) begin
			if (c < nc) begin
				if (op == OP_NEAREST) begin
					res[c] = texel_mem[y * DIM + x][c];
				end else begin
					sum = texel_mem[y * DIM + x][c] + texel_mem[y * DIM + x - 1][c]
						+ texel_mem[(y - 1) * DIM + x][c]
						+ texel_mem[(y - 1) * DIM + x - 1][c];
					res[c] = 8'(sum >> 2);
				end
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		texel_t got, want, wr;
		int unsigned w, h, nc;
		int c;
		bit bad;
		if (!arst_n) begin
			width_reg = 8'(DIM_RESET);
			height_reg = 8'(DIM_RESET);
			chans_reg = CHAN_CNT_W'(CHAN_RESET);
			fail_count <= 0;
			open_count <= 0;
			checked_count <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {chan_out_3, chan_out_2, chan_out_1, chan_out_0};
				if (expected_texels.size() == 0) begin
					if (mismatches < 10) begin
						$display("%0t: result %h with no sample outstanding", $realtime, got);
					end
					mismatches++;
				end else begin
					want = expected_texels.pop_front();
					compared++;
					bad = 1'b0;
					for (c = 0; c < PORT_CHANS; c++) begin
						if (got[c] !== want[c]) begin
							bad = 1'b1;
						end
					end
					if (bad) begin
						if (mismatches < 10) begin
							$display("%0t: chan_out_0..3 expected %h %h %h %h, got %h %h %h %h",
								$realtime, want[0], want[1], want[2], want[3],
								got[0], got[1], got[2], got[3]);
						end
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				w = clamp_to(width_reg, 2, DIM);
				h = clamp_to(height_reg, 2, DIM);
				nc = clamp_to(chans_reg, 1, PORT_CHANS);
				case (operation)
					OP_WRITE: begin
						if (x_pos < w && y_pos < h) begin
							wr = {chan_in_3, chan_in_2, chan_in_1, chan_in_0};
							for (c = 0; c < PORT_CHANS; c++) begin
								if (c >= nc) begin
									wr[c] = '0;
								end
							end
							texel_mem[y_pos * DIM + x_pos] = wr;
						end
					end
					OP_NEAREST, OP_BOX: begin
						expected_texels.push_back(filter_texels(operation, u_coord, v_coord));
					end
					default: begin
					end
				endcase
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TEX_WIDTH: width_reg = cfg_data;
					REG_TEX_HEIGHT: height_reg = cfg_data;
					REG_CHANNEL_COUNT: chans_reg = cfg_data[CHAN_CNT_W-1:0];
					default: begin
					end
				endcase
			end
			fail_count <= mismatches;
			open_count <= expected_texels.size();
			checked_count <= compared;
		end
	end

endmodule

// ===== verif/texture_sampler_nearest_box_unit_test.sv =====
// Testbench top for texture_sampler_nearest_box_unit: clock, reset, stimulus with
// random idling and a long output hold-off, and the verdict.
// Depends on tsnb_pkg, the unit and texture_sampler_nearest_box_checker.
`timescale 1ns / 1ps

module texture_sampler_nearest_box_unit_test;
	import tsnb_pkg::*;

	localparam int DIM = 128;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int MIXED_ITEMS = 190;
	localparam int LIMIT_NS = 4_000_000;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [6:0] x;
		logic [6:0] y;
		logic [3:0][7:0] chans;
		logic [COORD_W-1:0] u;
		logic [COORD_W-1:0] v;
	} texel_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OP_W-1:0] operation = OP_WRITE;
	logic [6:0] x_pos = '0;
	logic [6:0] y_pos = '0;
	logic [7:0] chan_in_0 = '0;
	logic [7:0] chan_in_1 = '0;
	logic [7:0] chan_in_2 = '0;
	logic [7:0] chan_in_3 = '0;
	logic signed [COORD_W-1:0] u_coord = '0;
	logic signed [COORD_W-1:0] v_coord = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] chan_out_0;
	logic [7:0] chan_out_1;
	logic [7:0] chan_out_2;
	logic [7:0] chan_out_3;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index = REG_TEX_WIDTH;
	logic [7:0] cfg_data = '0;
	int fail_count;
	int open_count;
	int checked_count;

	idle_mode_t idle_mode = IDLE_NONE;
	logic hold_armed = 1'b0;
	int hold_count = 0;
	bit written [0:DIM-1][0:DIM-1];
	int eff_w = DIM;
	int eff_h = DIM;
	int rx0, rx1, ry0, ry1;
	int items_sent = 0;
	int samples_sent = 0;
	int settings_used = 1;

	texture_sampler_nearest_box_unit dut (.*);

	texture_sampler_nearest_box_checker checker_i (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int gap_pct(idle_mode_t m);
		return (m == IDLE_SENDER) ? 56 : (m == IDLE_BOTH) ? 19 : 0;
	endfunction

	function automatic int stall_pct(idle_mode_t m);
		return (m == IDLE_RECEIVER) ? 56 : (m == IDLE_BOTH) ? 19 : 0;
	endfunction

	// long hold-off once armed, random stalls otherwise
	always @(posedge clk) begin
		if (hold_armed && hold_count < HOLD_CYCLES) begin
			out_stall <= 1'b1;
			hold_count <= hold_count + 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct(idle_mode));
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int clamp_int(int val, int lo, int hi);
		return (val < lo) ? lo : (val > hi) ? hi : val;
	endfunction

	function automatic int texel_index_for(logic signed [COORD_W-1:0] coord, int size, int lo);
		int s;
		s = coord;
		s = clamp_int(s, 0, int'(ONE_Q16));
		return clamp_int((s * size) >>> FRAC_BITS, lo, size - 1);
	endfunction

	// random coordinate that lands on texel idx of a dimension of the given size
	function automatic logic [COORD_W-1:0] coord_for(int idx, int size);
		int lo, hi;
		lo = (idx * 65536 + size - 1) / size;
		hi = ((idx + 1) * 65536 - 1) / size;
		return COORD_W'($urandom_range(lo, hi));
	endfunction

	function automatic logic [COORD_W-1:0] random_coord();
		case ($urandom_range(0, 3))
			0: return COORD_W'($urandom);
			1: return COORD_W'($urandom_range(0, 65536));
			2: begin
				case ($urandom_range(0, 7))
					0: return 18'h20000;
					1: return 18'h3FFFF;
					2: return 18'h00000;
					3: return 18'h00001;
					4: return 18'h0FFFF;
					5: return 18'h10000;
					6: return 18'h10001;
					default: return 18'h1FFFF;
				endcase
			end
			default: return COORD_W'($urandom_range(60000, 70000));
		endcase
	endfunction

	function automatic texel_cmd_t write_cmd(int x, int y, logic [31:0] chans);
		texel_cmd_t cmd;
		cmd.op = OP_WRITE;
		cmd.x = 7'(x);
		cmd.y = 7'(y);
		cmd.chans = chans;
		cmd.u = COORD_W'($urandom);
		cmd.v = COORD_W'($urandom);
		return cmd;
	endfunction

	function automatic texel_cmd_t sample_cmd(logic [OP_W-1:0] op, logic [COORD_W-1:0] u,
			logic [COORD_W-1:0] v);
		texel_cmd_t cmd;
		cmd.op = op;
		cmd.x = 7'($urandom);
		cmd.y = 7'($urandom);
		cmd.chans = $urandom;
		cmd.u = u;
		cmd.v = v;
		return cmd;
	endfunction

	function automatic bit footprint_written(texel_cmd_t cmd);
		int lo, ix, iy;
		lo = (cmd.op == OP_BOX) ? 1 : 0;
		ix = texel_index_for(cmd.u, eff_w, lo);
		iy = texel_index_for(cmd.v, eff_h, lo);
		if (cmd.op == OP_NEAREST) begin
			return written[iy][ix];
		end
		return written[iy][ix] && written[iy][ix - 1] && written[iy - 1][ix]
			&& written[iy - 1][ix - 1];
	endfunction

	function automatic texel_cmd_t mixed_cmd();
		int roll, k;
		texel_cmd_t cmd;
		roll = $urandom_range(0, 99);
		if (roll < 25) begin
			if ($urandom_range(0, 4) == 0) begin
				return write_cmd($urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1), $urandom);
			end
			return write_cmd($urandom_range(0, eff_w - 1), $urandom_range(0, eff_h - 1),
				$urandom);
		end
		if (roll < 30) begin
			return sample_cmd(OP_UNUSED, COORD_W'($urandom), COORD_W'($urandom));
		end
		cmd = sample_cmd(($urandom_range(0, 1) == 1) ? OP_BOX : OP_NEAREST, '0, '0);
		for (k = 0; k < 6; k++) begin
			cmd.u = random_coord();
			cmd.v = random_coord();
			if (footprint_written(cmd)) begin
				return cmd;
			end
		end
		// aim inside the region filled at the start of the phase
		if (cmd.op == OP_BOX) begin
			cmd.u = coord_for($urandom_range(rx0 + 1, rx1), eff_w);
			cmd.v = coord_for($urandom_range(ry0 + 1, ry1), eff_h);
		end else begin
			cmd.u = coord_for($urandom_range(rx0, rx1), eff_w);
			cmd.v = coord_for($urandom_range(ry0, ry1), eff_h);
		end
		return cmd;
	endfunction

	task automatic push_item(texel_cmd_t cmd);
		while ($urandom_range(0, 99) < gap_pct(idle_mode)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= cmd.op;
		x_pos <= cmd.x;
		y_pos <= cmd.y;
		chan_in_0 <= cmd.chans[0];
		chan_in_1 <= cmd.chans[1];
		chan_in_2 <= cmd.chans[2];
		chan_in_3 <= cmd.chans[3];
		u_coord <= cmd.u;
		v_coord <= cmd.v;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		items_sent++;
		if (cmd.op == OP_NEAREST || cmd.op == OP_BOX) begin
			samples_sent++;
		end
		if (cmd.op == OP_WRITE && cmd.x < eff_w && cmd.y < eff_h) begin
			written[cmd.y][cmd.x] = 1'b1;
		end
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (open_count != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int pick_origin(int size, int span);
		case ($urandom_range(0, 2))
			0: return 0;
			1: return size - span;
			default: return $urandom_range(0, size - span);
		endcase
	endfunction

	task automatic run_phase(int raw_w, int raw_h, int raw_c, idle_mode_t mode, bit squeeze);
		int rw, rh, x, y;
		write_reg(REG_TEX_WIDTH, 8'(raw_w));
		write_reg(REG_TEX_HEIGHT, 8'(raw_h));
		write_reg(REG_CHANNEL_COUNT, 8'(raw_c));
		cfg_valid <= 1'b0;
		idle_mode <= mode;
		eff_w = clamp_int(raw_w, 2, DIM);
		eff_h = clamp_int(raw_h, 2, DIM);
		@(posedge clk);
		rw = $urandom_range(2, clamp_int(eff_w, 2, 8));
		rh = $urandom_range(2, clamp_int(eff_h, 2, 8));
		rx0 = pick_origin(eff_w, rw);
		ry0 = pick_origin(eff_h, rh);
		rx1 = rx0 + rw - 1;
		ry1 = ry0 + rh - 1;
		for (y = ry0; y <= ry1; y++) begin
			for (x = rx0; x <= rx1; x++) begin
				push_item(write_cmd(x, y, $urandom));
			end
		end
		if (squeeze) begin
			hold_armed <= 1'b1;
		end
		repeat (MIXED_ITEMS) push_item(mixed_cmd());
		wait_idle();
		settings_used++;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner texels at the reset size, then samples at the coordinate extremes
		push_item(write_cmd(0, 0, 32'h00000000));
		push_item(write_cmd(1, 0, 32'hFFFFFFFF));
		push_item(write_cmd(0, 1, 32'hF00FAA55));
		push_item(write_cmd(1, 1, 32'hFE7F8001));
		push_item(write_cmd(126, 126, $urandom));
		push_item(write_cmd(127, 126, $urandom));
		push_item(write_cmd(126, 127, $urandom));
		push_item(write_cmd(127, 127, 32'hFFFFFFFF));
		push_item(sample_cmd(OP_UNUSED, 18'h10000, 18'h10000));
		push_item(sample_cmd(OP_NEAREST, 18'h20000, 18'h20000));
		push_item(sample_cmd(OP_NEAREST, 18'h00000, 18'h00000));
		push_item(sample_cmd(OP_NEAREST, 18'h00200, 18'h00000));
		push_item(sample_cmd(OP_NEAREST, 18'h10000, 18'h10000));
		push_item(sample_cmd(OP_NEAREST, 18'h1FFFF, 18'h1FFFF));
		push_item(sample_cmd(OP_NEAREST, 18'h0FFFF, 18'h0FE00));
		push_item(sample_cmd(OP_BOX, 18'h00000, 18'h00000));
		push_item(sample_cmd(OP_BOX, 18'h3FFFF, 18'h3FFFF));
		push_item(sample_cmd(OP_BOX, 18'h10000, 18'h1FFFF));
		push_item(sample_cmd(OP_BOX, 18'h00380, 18'h00300));
		wait_idle();

		run_phase(2, 2, 1, IDLE_SENDER, 1'b0);
		run_phase(128, 128, 4, IDLE_NONE, 1'b1);
		run_phase(0, 255, 0, IDLE_RECEIVER, 1'b0);
		run_phase(255, 1, 7, IDLE_BOTH, 1'b0);
		run_phase(128, 2, 3, IDLE_NONE, 1'b0);
		run_phase(2, 128, 2, IDLE_SENDER, 1'b0);
		run_phase($urandom_range(2, 128), $urandom_range(2, 128), $urandom_range(1, 4),
			IDLE_BOTH, 1'b0);
		run_phase($urandom_range(2, 128), $urandom_range(2, 128), $urandom_range(1, 4),
			IDLE_RECEIVER, 1'b0);
		run_phase($urandom_range(2, 16), $urandom_range(2, 16), $urandom_range(1, 4),
			IDLE_NONE, 1'b0);

		$display("run covered %0d transactions (%0d samples) over %0d register settings,",
			items_sent, samples_sent, settings_used);
		$display("with a %0d-cycle output hold-off; %0d results compared, %0d mismatches",
			HOLD_CYCLES, checked_count, fail_count);
		if (fail_count == 0 && open_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/tsnb_pkg.sv
hw/rtl/tsnb_texel_bank.sv
hw/rtl/texture_sampler_nearest_box_unit.sv
verif/texture_sampler_nearest_box_checker.sv
verif/texture_sampler_nearest_box_unit_test.sv
